[rtl/bir_pkg.sv]
// Shared types and constants of the bilinear image resize core.
// Used by the controller, the datapath and the top level; depends on nothing.
package bir_pkg;

  localparam int SIZE_W = 9;
  localparam int STEP_W = 24;
  localparam int CH_W = 8;
  localparam int PIX_W = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IN_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_X_STEP = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_Y_STEP = 3'd5;

  typedef struct packed {
    logic       store_en;
    logic       pos_en;
    logic       idx_en;
    logic       base_en;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
    logic       row_en;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } stat_t;

endpackage

[rtl/bir_ram.sv]
// Generic single-port RAM with registered read data.
// Standalone; used for the frame store.
module bir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/bir_ctrl.sv]
// Sequencer of the bilinear image resize core: accepts transactions and steps
// the datapath through position, index, row base, four reads and two blend passes. Uses bir_pkg.
module bir_ctrl import bir_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  logic  in_operation,
  output logic  in_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_POS  = 4'd1;
  localparam logic [3:0] S_IDX  = 4'd2;
  localparam logic [3:0] S_BASE = 4'd3;
  localparam logic [3:0] S_RD0  = 4'd4;
  localparam logic [3:0] S_RD1  = 4'd5;
  localparam logic [3:0] S_RD2  = 4'd6;
  localparam logic [3:0] S_RD3  = 4'd7;
  localparam logic [3:0] S_WAIT = 4'd8;
  localparam logic [3:0] S_ROW  = 4'd9;
  localparam logic [3:0] S_COL  = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation) begin
            state_nxt = S_POS;
          end else begin
            cmd.store_en = 1'b1;
          end
        end
      end
      S_POS: begin
        cmd.pos_en = 1'b1;
        state_nxt = S_IDX;
      end
      S_IDX: begin
        cmd.idx_en = 1'b1;
        state_nxt = S_BASE;
      end
      S_BASE: begin
        cmd.base_en = 1'b1;
        state_nxt = S_RD0;
      end
      S_RD0: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd0;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd1;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd0;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd2;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd1;
        state_nxt = S_RD3;
      end
      S_RD3: begin
        cmd.rd_en = 1'b1;
        cmd.rd_sel = 2'd3;
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd2;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        cmd.cap_en = 1'b1;
        cmd.cap_sel = 2'd3;
        state_nxt = S_ROW;
      end
      S_ROW: begin
        cmd.row_en = 1'b1;
        state_nxt = S_COL;
      end
      S_COL: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/bir_dpath.sv]
// Datapath of the bilinear image resize core: frame store, load address, output
// counters, position arithmetic, row and column blends and the output register.
// Uses bir_pkg and bir_ram.
module bir_dpath import bir_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [SIZE_W-1:0] cfg_in_width,
  input  logic [SIZE_W-1:0] cfg_in_height,
  input  logic [SIZE_W-1:0] cfg_out_width,
  input  logic [SIZE_W-1:0] cfg_out_height,
  input  logic [STEP_W-1:0] cfg_x_step,
  input  logic [STEP_W-1:0] cfg_y_step,
  input  logic [CH_W-1:0]   src_red,
  input  logic [CH_W-1:0]   src_green,
  input  logic [CH_W-1:0]   src_blue,
  input  logic [CH_W-1:0]   src_alpha,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [CH_W-1:0]   out_red,
  output logic [CH_W-1:0]   out_green,
  output logic [CH_W-1:0]   out_blue,
  output logic [CH_W-1:0]   out_alpha,
  output logic              out_frame_last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW = $clog2(DEPTH);
  localparam int WCL = $clog2(MAX_WIDTH + 1);
  localparam int HCL = $clog2(MAX_HEIGHT + 1);
  localparam int WEW = (WCL > SIZE_W) ? WCL : SIZE_W;
  localparam int HEW = (HCL > SIZE_W) ? HCL : SIZE_W;
  localparam int TW = WEW + HEW;
  localparam int XPW = CW + STEP_W;
  localparam int YPW = RW + STEP_W;

  function automatic logic [CH_W-1:0] blend8(input logic [CH_W-1:0] lo,
                                             input logic [CH_W-1:0] hi,
                                             input logic [FRAC_BITS-1:0] f);
    logic signed [CH_W:0] d;
    logic signed [CH_W+FRAC_BITS+1:0] prod;
    logic signed [CH_W+FRAC_BITS+1:0] sh;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    prod = d * $signed({1'b0, f});
    sh = prod >>> FRAC_BITS;
    return lo + sh[CH_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] lo,
                                                input logic [PIX_W-1:0] hi,
                                                input logic [FRAC_BITS-1:0] f);
    logic [PIX_W-1:0] res;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      res[ch*CH_W +: CH_W] = blend8(lo[ch*CH_W +: CH_W], hi[ch*CH_W +: CH_W], f);
    end
    return res;
  endfunction

  logic [WEW-1:0] iw, ow, w_raw, ow_raw;
  logic [HEW-1:0] ih, oh, h_raw, oh_raw;

  assign w_raw = WEW'(cfg_in_width);
  assign ow_raw = WEW'(cfg_out_width);
  assign h_raw = HEW'(cfg_in_height);
  assign oh_raw = HEW'(cfg_out_height);

  always_comb begin
    priority if (w_raw == '0) iw = WEW'(1);
    else if (w_raw > WEW'(MAX_WIDTH)) iw = WEW'(MAX_WIDTH);
    else iw = w_raw;
    priority if (ow_raw == '0) ow = WEW'(1);
    else if (ow_raw > WEW'(MAX_WIDTH)) ow = WEW'(MAX_WIDTH);
    else ow = ow_raw;
    priority if (h_raw == '0) ih = HEW'(1);
    else if (h_raw > HEW'(MAX_HEIGHT)) ih = HEW'(MAX_HEIGHT);
    else ih = h_raw;
    priority if (oh_raw == '0) oh = HEW'(1);
    else if (oh_raw > HEW'(MAX_HEIGHT)) oh = HEW'(MAX_HEIGHT);
    else oh = oh_raw;
  end

  logic [AW-1:0] ld_r;
  logic [TW-1:0] total;
  logic          ld_wrap;

  assign total = {{HEW{1'b0}}, iw} * {{WEW{1'b0}}, ih};
  assign ld_wrap = (TW'(ld_r) + TW'(1)) >= total;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          end_row, end_frame;

  assign end_row = (WEW'(col_r) + WEW'(1)) >= ow;
  assign end_frame = end_row && ((HEW'(row_r) + HEW'(1)) >= oh);

  logic [XPW-1:0] xpos_r;
  logic [YPW-1:0] ypos_r;

  logic [CW-1:0]        x0_r, x1_r, x0_nxt, x1_nxt;
  logic [RW-1:0]        y0_r, y1_r, y0_nxt, y1_nxt;
  logic [FRAC_BITS-1:0] fx_r, fy_r;
  logic [XPW-1:0]       xip, xlast;
  logic [YPW-1:0]       yip, ylast;

  assign xip = xpos_r >> FRAC_BITS;
  assign yip = ypos_r >> FRAC_BITS;
  assign xlast = XPW'(iw) - XPW'(1);
  assign ylast = YPW'(ih) - YPW'(1);

  always_comb begin
    x0_nxt = (xip > xlast) ? CW'(xlast) : CW'(xip);
    x1_nxt = ((XPW'(x0_nxt) + XPW'(1)) > xlast) ? CW'(xlast) : CW'(XPW'(x0_nxt) + XPW'(1));
    y0_nxt = (yip > ylast) ? RW'(ylast) : RW'(yip);
    y1_nxt = ((YPW'(y0_nxt) + YPW'(1)) > ylast) ? RW'(ylast) : RW'(YPW'(y0_nxt) + YPW'(1));
  end

  logic [RW+WEW-1:0] b0_prod, b1_prod;
  logic [AW-1:0]     base0_r, base1_r;

  assign b0_prod = {{WEW{1'b0}}, y0_r} * {{RW{1'b0}}, iw};
  assign b1_prod = {{WEW{1'b0}}, y1_r} * {{RW{1'b0}}, iw};

  logic [AW-1:0]    ram_addr;
  logic [PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0] ram_wdata;

  assign ram_wdata = {src_alpha, src_blue, src_green, src_red};

  always_comb begin
    if (cmd.rd_en) begin
      unique case (cmd.rd_sel)
        2'd0: ram_addr = base0_r + AW'(x0_r);
        2'd1: ram_addr = base0_r + AW'(x1_r);
        2'd2: ram_addr = base1_r + AW'(x0_r);
        default: ram_addr = base1_r + AW'(x1_r);
      endcase
    end else begin
      ram_addr = ld_r;
    end
  end

  bir_ram #(
    .WIDTH(PIX_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.store_en),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  logic [PIX_W-1:0] px_r [4];
  logic [PIX_W-1:0] top_r, bot_r, pix;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r;

  assign pix = blend_px(top_r, bot_r, fy_r);

  always_ff @(posedge clk) begin
    if (cmd.pos_en) begin
      xpos_r <= {{STEP_W{1'b0}}, col_r} * {{CW{1'b0}}, cfg_x_step};
      ypos_r <= {{STEP_W{1'b0}}, row_r} * {{RW{1'b0}}, cfg_y_step};
    end
    if (cmd.idx_en) begin
      x0_r <= x0_nxt;
      x1_r <= x1_nxt;
      y0_r <= y0_nxt;
      y1_r <= y1_nxt;
      fx_r <= xpos_r[FRAC_BITS-1:0];
      fy_r <= ypos_r[FRAC_BITS-1:0];
    end
    if (cmd.base_en) begin
      base0_r <= b0_prod[AW-1:0];
      base1_r <= b1_prod[AW-1:0];
    end
    if (cmd.cap_en) begin
      px_r[cmd.cap_sel] <= ram_rdata;
    end
    if (cmd.row_en) begin
      top_r <= blend_px(px_r[0], px_r[1], fx_r);
      bot_r <= blend_px(px_r[2], px_r[3], fx_r);
    end
    if (cmd.out_load) begin
      out_pix_r <= pix;
      out_last_r <= end_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r <= '0;
      col_r <= '0;
      row_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.store_en) begin
        ld_r <= ld_wrap ? '0 : ld_r + AW'(1);
      end
      if (cmd.out_load) begin
        if (end_row) begin
          col_r <= '0;
          row_r <= end_frame ? '0 : row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign stat.out_busy = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_red = out_pix_r[0 +: CH_W];
  assign out_green = out_pix_r[CH_W +: CH_W];
  assign out_blue = out_pix_r[2*CH_W +: CH_W];
  assign out_alpha = out_pix_r[3*CH_W +: CH_W];
  assign out_frame_last = out_last_r;

endmodule

[rtl/bilinear_image_resize_core.sv]
// Bilinear RGBA8 image scaler. A store transaction writes one source pixel into
// the frame store in raster order. A fetch transaction puts the next output pixel
// on the result channel after these steps: position multiply, index clamp, row
// base multiply, four reads through the single port of the frame store plus a wait
// state for the last read data, the row blend and the column blend. The input
// stalls until the result is loaded, so no new transaction is taken while a fetch
// is in progress. A fetch whose result finds the previous one still waiting under
// out_stall holds the input for as long as that stall lasts. The result sits in
// an output register while new stores are accepted. Uses bir_pkg, bir_ctrl and
// bir_dpath.
module bilinear_image_resize_core import bir_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [STEP_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_operation,
  input  logic [CH_W-1:0]      in_src_red,
  input  logic [CH_W-1:0]      in_src_green,
  input  logic [CH_W-1:0]      in_src_blue,
  input  logic [CH_W-1:0]      in_src_alpha,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CH_W-1:0]      out_red,
  output logic [CH_W-1:0]      out_green,
  output logic [CH_W-1:0]      out_blue,
  output logic [CH_W-1:0]      out_alpha,
  output logic                 out_frame_last
);

  logic [SIZE_W-1:0] in_width_r, in_height_r, out_width_r, out_height_r;
  logic [STEP_W-1:0] x_step_r, y_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_width_r <= SIZE_W'(256);
      in_height_r <= SIZE_W'(256);
      out_width_r <= SIZE_W'(256);
      out_height_r <= SIZE_W'(256);
      x_step_r <= STEP_W'(65536);
      y_step_r <= STEP_W'(65536);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IN_WIDTH: in_width_r <= cfg_wdata[SIZE_W-1:0];
        REG_IN_HEIGHT: in_height_r <= cfg_wdata[SIZE_W-1:0];
        REG_OUT_WIDTH: out_width_r <= cfg_wdata[SIZE_W-1:0];
        REG_OUT_HEIGHT: out_height_r <= cfg_wdata[SIZE_W-1:0];
        REG_X_STEP: x_step_r <= cfg_wdata;
        REG_Y_STEP: y_step_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  cmd_t  cmd;
  stat_t stat;

  bir_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_operation(in_operation),
    .in_stall    (in_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  bir_dpath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_in_width  (in_width_r),
    .cfg_in_height (in_height_r),
    .cfg_out_width (out_width_r),
    .cfg_out_height(out_height_r),
    .cfg_x_step    (x_step_r),
    .cfg_y_step    (y_step_r),
    .src_red       (in_src_red),
    .src_green     (in_src_green),
    .src_blue      (in_src_blue),
    .src_alpha     (in_src_alpha),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .out_frame_last(out_frame_last)
  );

`ifndef ASSERT_OFF
  a_fetch_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_operation |=> in_stall)
    else $error("input accepted while a fetch is in progress");

  a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_operation && !out_valid |=> !out_valid)
    else $error("store transaction produced a result");

  a_reset_clears_out: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for bilinear_image_resize_core: loads source frames,
// fetches scaled pixels and compares them with a built-in separable bilinear predictor.
// Depends on bir_pkg and the core RTL only.
module testbench;
  import bir_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 256;
  localparam int MAX_H = 256;
  localparam int FRAC = 16;
  localparam int LIMIT = 3000000;
  localparam logic OP_STORE = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [STEP_W-1:0] cfg_wdata;
  logic in_valid, in_stall, in_operation;
  logic [CH_W-1:0] in_src_red, in_src_green, in_src_blue, in_src_alpha;
  logic out_valid, out_stall;
  logic [CH_W-1:0] out_red, out_green, out_blue, out_alpha;
  logic out_frame_last;

  bilinear_image_resize_core u_top (.*);

  logic [31:0] frame_mem [MAX_W*MAX_H];
  int unsigned reg_in_w = 256, reg_in_h = 256, reg_out_w = 256, reg_out_h = 256;
  int unsigned reg_x_step = 65536, reg_y_step = 65536;
  int unsigned load_addr, col_pos, row_pos;

  pixel_t expected_pixels[$];
  int errors, n_items, n_fetched, n_frames, cycles;
  bit quiet, hold_req, hold_done;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("bilinear_image_resize_core regression: fail");
      $finish;
    end
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned mx);
    if (v == 0) return 1;
    return v > mx ? mx : v;
  endfunction

  function automatic logic [31:0] mix_pixel(logic [31:0] lo, logic [31:0] hi, int unsigned f);
    logic [31:0] res;
    int unsigned a, b;
    res = '0;
    for (int ch = 0; ch < 4; ch++) begin
      a = lo[8*ch +: 8];
      b = hi[8*ch +: 8];
      res[8*ch +: 8] = 8'((((1 << FRAC) - f) * a + f * b) >> FRAC);
    end
    return res;
  endfunction

  task automatic split_pos(input int unsigned idx, input int unsigned step,
                           input int unsigned size, output int unsigned i0,
                           output int unsigned i1, output int unsigned f);
    longint unsigned pos, ip;
    pos = longint'(idx) * longint'(step);
    ip = pos >> FRAC;
    f = 32'(pos & ((1 << FRAC) - 1));
    i0 = ip > size - 1 ? size - 1 : int'(ip);
    i1 = i0 + 1 > size - 1 ? size - 1 : i0 + 1;
  endtask

  task automatic predict_pixel(input logic op, input logic [31:0] px);
    int unsigned iw, ih, ow, oh, x0, x1, fx, y0, y1, fy;
    logic [31:0] top, bot, res;
    pixel_t p;
    bit end_row, end_frame;
    iw = clamp_size(reg_in_w, MAX_W);
    ih = clamp_size(reg_in_h, MAX_H);
    ow = clamp_size(reg_out_w, MAX_W);
    oh = clamp_size(reg_out_h, MAX_H);
    if (op == OP_STORE) begin
      frame_mem[load_addr] = px;
      load_addr = (load_addr + 1 >= iw * ih) ? 0 : load_addr + 1;
    end else begin
      split_pos(col_pos, reg_x_step, iw, x0, x1, fx);
      split_pos(row_pos, reg_y_step, ih, y0, y1, fy);
      top = mix_pixel(frame_mem[y0*iw + x0], frame_mem[y0*iw + x1], fx);
      bot = mix_pixel(frame_mem[y1*iw + x0], frame_mem[y1*iw + x1], fx);
      res = mix_pixel(top, bot, fy);
      end_row = col_pos + 1 >= ow;
      end_frame = end_row && row_pos + 1 >= oh;
      p.red = res[7:0];
      p.green = res[15:8];
      p.blue = res[23:16];
      p.alpha = res[31:24];
      p.last = end_frame;
      expected_pixels.push_back(p);
      if (end_row) begin
        col_pos = 0;
        row_pos = end_frame ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    end
  endtask

  task automatic report(input string what, input int unsigned got, input int unsigned want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    pixel_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        e = expected_pixels.pop_front();
        n_fetched++;
        if (out_frame_last) n_frames++;
        if (out_red !== e.red) report("red", out_red, e.red);
        if (out_green !== e.green) report("green", out_green, e.green);
        if (out_blue !== e.blue) report("blue", out_blue, e.blue);
        if (out_alpha !== e.alpha) report("alpha", out_alpha, e.alpha);
        if (out_frame_last !== e.last) report("frame_last", out_frame_last, e.last);
      end
    end
  end

  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_done = 1;
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic op, input logic [31:0] px);
    in_valid <= 1'b1;
    in_operation <= op;
    in_src_red <= px[7:0];
    in_src_green <= px[15:8];
    in_src_blue <= px[23:16];
    in_src_alpha <= px[31:24];
    do @(posedge clk); while (in_stall);
    predict_pixel(op, px);
    n_items++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v[STEP_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_IN_WIDTH: reg_in_w = v & 'h1FF;
      REG_IN_HEIGHT: reg_in_h = v & 'h1FF;
      REG_OUT_WIDTH: reg_out_w = v & 'h1FF;
      REG_OUT_HEIGHT: reg_out_h = v & 'h1FF;
      REG_X_STEP: reg_x_step = v & 'hFFFFFF;
      REG_Y_STEP: reg_y_step = v & 'hFFFFFF;
      default: ;
    endcase
  endtask

  task automatic setup_frame(input int unsigned iw, ih, ow, oh, xs, ys);
    int unsigned total;
    drain();
    write_reg(REG_IN_WIDTH, iw);
    write_reg(REG_IN_HEIGHT, ih);
    write_reg(REG_OUT_WIDTH, ow);
    write_reg(REG_OUT_HEIGHT, oh);
    write_reg(REG_X_STEP, xs);
    write_reg(REG_Y_STEP, ys);
    total = clamp_size(iw & 'h1FF, MAX_W) * clamp_size(ih & 'h1FF, MAX_H);
    // One extra store makes sure the load address has wrapped over the whole frame.
    for (int i = 0; i <= total; i++) send_item(OP_STORE, $urandom());
  endtask

  function automatic int unsigned ratio_step(int unsigned i, int unsigned o);
    if (o <= 1) return $urandom_range(0, 'h30000);
    return ((i - 1) << FRAC) / (o - 1);
  endfunction

  task automatic test_directed();
    logic [31:0] pats [6] = '{32'h0, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555,
                               32'hFF00FF00, 32'h00FF00FF};
    setup_frame(4, 3, 7, 5, 32768, 32768);
    for (int i = 0; i < 6; i++) send_item(OP_STORE, pats[i]);
    for (int i = 0; i < 12; i++) send_item(OP_FETCH, $urandom());
  endtask

  task automatic test_register_extremes();
    setup_frame(0, 3, 0, 2, 0, 'hFFFFFF);
    repeat (4) send_item(OP_FETCH, 0);
    setup_frame(511, 1, 300, 1, 'hFFFFFF, 0);
    repeat (10) send_item(OP_FETCH, 0);
    setup_frame(1, 256, 1, 511, 0, 65536);
    repeat (10) send_item(OP_FETCH, 0);
    setup_frame(5, 5, 3, 3, 'h20000, 'h20000);
    repeat (12) send_item(OP_FETCH, 0);
  endtask

  task automatic test_random_frames();
    int unsigned iw, ih, ow, oh, n;
    while (n_items < 1700) begin
      iw = $urandom_range(1, 12);
      ih = $urandom_range(1, 12);
      ow = $urandom_range(1, 10);
      oh = $urandom_range(1, 10);
      setup_frame(iw, ih, ow, oh,
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 'hFFFFFF) : ratio_step(iw, ow),
                  $urandom_range(0, 3) == 0 ? $urandom_range(0, 'hFFFFFF) : ratio_step(ih, oh));
      n = $urandom_range(20, 60);
      repeat (n) send_item($urandom_range(0, 9) < 7 ? OP_FETCH : OP_STORE, $urandom());
    end
  endtask

  task automatic test_output_hold();
    setup_frame(6, 6, 8, 8, 'h0A000, 'h0A000);
    hold_done = 0;
    hold_req = 1;
    repeat (40) send_item(OP_FETCH, 0);
    while (!hold_done) @(posedge clk);
  endtask

  task automatic test_steady_stream();
    setup_frame(8, 4, 9, 5, 'h0E38E, 'h0C000);
    quiet = 1;
    repeat (120) send_item($urandom_range(0, 4) == 0 ? OP_STORE : OP_FETCH, $urandom());
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_operation = OP_STORE;
    in_src_red = '0;
    in_src_green = '0;
    in_src_blue = '0;
    in_src_alpha = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_output_hold();
    test_random_frames();
    test_steady_stream();
    drain();
    $display("Sent %0d transactions; checked %0d output pixels across %0d complete frames.",
             n_items, n_fetched, n_frames);
    if (errors == 0) begin
      $display("bilinear_image_resize_core regression: pass");
    end else begin
      $display("bilinear_image_resize_core regression: fail");
    end
    $finish;
  end
endmodule
